// ===== rtl/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cee_pkg
// Types and constants shared by the EEPROM random-read I2C master.
// ----------------------------------------------------------------------------
package i2cee_pkg;

	localparam int DEV_CODE_W  = 7;
	localparam int BYTE_W      = 8;
	localparam int BIT_COUNT_W = 4;

	localparam logic [DEV_CODE_W-1:0]  DEV_CODE_RESET = 7'h50;
	localparam logic [BIT_COUNT_W-1:0] BITS_PER_BYTE  = 4'd8;

	typedef enum logic [15:0] {
		ST_IDLE   = 16'h0001,
		ST_START  = 16'h0002,
		ST_DEVW   = 16'h0004,
		ST_ACK1   = 16'h0008,
		ST_ADDR   = 16'h0010,
		ST_ACK2   = 16'h0020,
		ST_RS_A   = 16'h0040,
		ST_RS_B   = 16'h0080,
		ST_RS_C   = 16'h0100,
		ST_DEVR   = 16'h0200,
		ST_ACK3   = 16'h0400,
		ST_READ   = 16'h0800,
		ST_NACK   = 16'h1000,
		ST_STOP_A = 16'h2000,
		ST_STOP_B = 16'h4000,
		ST_STOP_C = 16'h8000
	} step_t;

	typedef struct packed {
		step_t                  step;
		logic [BIT_COUNT_W-1:0] bit_count;
		logic                   phase;
		logic [BYTE_W-1:0]      shift;
		logic [BYTE_W-1:0]      addr;
		logic                   nack;
	} seq_state_t;

	typedef struct packed {
		logic              scl_level;
		logic              sda_release;
		logic              busy_res;
		logic              data_valid;
		logic [BYTE_W-1:0] read_data;
		logic              ack_failed;
	} seq_result_t;

endpackage

// ===== rtl/i2cee_req_if.sv =====
// ----------------------------------------------------------------------------
// i2cee_req_if
// Tick channel: request, word address and sampled SDA level.
// ----------------------------------------------------------------------------
interface i2cee_req_if
	import i2cee_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              request_read;
	logic [BYTE_W-1:0] word_address;
	logic              sda_sample;

	modport source (output valid, output request_read, output word_address,
		output sda_sample, input ready);
	modport sink (input valid, input request_read, input word_address,
		input sda_sample, output ready);
endinterface

// ===== rtl/i2cee_res_if.sv =====
// ----------------------------------------------------------------------------
// i2cee_res_if
// Result channel: bus levels and status for one tick.
// ----------------------------------------------------------------------------
interface i2cee_res_if
	import i2cee_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              scl_level;
	logic              sda_release;
	logic              busy_res;
	logic              data_valid;
	logic [BYTE_W-1:0] read_data;
	logic              ack_failed;

	modport source (output valid, output scl_level, output sda_release,
		output busy_res, output data_valid, output read_data, output ack_failed,
		input ready);
	modport sink (input valid, input scl_level, input sda_release,
		input busy_res, input data_valid, input read_data, input ack_failed,
		output ready);
endinterface

// ===== rtl/i2cee_cfg_if.sv =====
// ----------------------------------------------------------------------------
// i2cee_cfg_if
// Configuration write channel for the device code.
// ----------------------------------------------------------------------------
interface i2cee_cfg_if
	import i2cee_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [DEV_CODE_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2cee_core.sv =====
// ----------------------------------------------------------------------------
// i2cee_core
// Next-state and bus-level logic for one half-bit tick of the sequencer.
// ----------------------------------------------------------------------------
module i2cee_core
	import i2cee_pkg::*;
(
	input  seq_state_t            cur,
	input  logic [DEV_CODE_W-1:0] device_code,
	input  logic                  request_read,
	input  logic [BYTE_W-1:0]     word_address,
	input  logic                  sda_sample,
	output seq_state_t            nxt,
	output seq_result_t           res
);

	logic [BIT_COUNT_W-1:0] bc_inc;
	logic                   byte_end;

	assign bc_inc   = BIT_COUNT_W'(cur.bit_count + 1'b1);
	assign byte_end = (bc_inc >= BITS_PER_BYTE);

	always_comb begin
		nxt             = cur;
		res.scl_level   = 1'b1;
		res.sda_release = 1'b1;
		res.busy_res    = 1'b1;
		res.data_valid  = 1'b0;
		res.read_data   = '0;
		case (cur.step)
			ST_START: begin
				res.sda_release = 1'b0;
				nxt.shift       = {device_code, 1'b0};
				nxt.bit_count   = '0;
				nxt.phase       = 1'b0;
				nxt.step        = ST_DEVW;
			end
			ST_DEVW, ST_ADDR, ST_DEVR: begin
				res.scl_level   = cur.phase;
				res.sda_release = cur.shift[BYTE_W-1];
				nxt.phase       = ~cur.phase;
				if (cur.phase) begin
					nxt.shift = {cur.shift[BYTE_W-2:0], 1'b0};
					if (byte_end) begin
						nxt.bit_count = '0;
						if (cur.step == ST_DEVW)
							nxt.step = ST_ACK1;
						else if (cur.step == ST_ADDR)
							nxt.step = ST_ACK2;
						else
							nxt.step = ST_ACK3;
					end else begin
						nxt.bit_count = bc_inc;
					end
				end
			end
			ST_ACK1, ST_ACK2, ST_ACK3: begin
				res.scl_level = cur.phase;
				nxt.phase     = ~cur.phase;
				if (cur.phase) begin
					if (sda_sample)
						nxt.nack = 1'b1;
					if (cur.step == ST_ACK1) begin
						nxt.shift = cur.addr;
						nxt.step  = ST_ADDR;
					end else if (cur.step == ST_ACK2) begin
						nxt.step = ST_RS_A;
					end else begin
						nxt.shift = '0;
						nxt.step  = ST_READ;
					end
				end
			end
			ST_RS_A: begin
				res.scl_level = 1'b0;
				nxt.step      = ST_RS_B;
			end
			ST_RS_B: begin
				nxt.step = ST_RS_C;
			end
			ST_RS_C: begin
				res.sda_release = 1'b0;
				nxt.shift       = {device_code, 1'b1};
				nxt.bit_count   = '0;
				nxt.phase       = 1'b0;
				nxt.step        = ST_DEVR;
			end
			ST_READ: begin
				res.scl_level = cur.phase;
				nxt.phase     = ~cur.phase;
				if (cur.phase) begin
					nxt.shift = {cur.shift[BYTE_W-2:0], sda_sample};
					if (byte_end) begin
						nxt.bit_count = '0;
						nxt.step      = ST_NACK;
					end else begin
						nxt.bit_count = bc_inc;
					end
				end
			end
			ST_NACK: begin
				res.scl_level = cur.phase;
				nxt.phase     = ~cur.phase;
				if (cur.phase)
					nxt.step = ST_STOP_A;
			end
			ST_STOP_A: begin
				res.scl_level   = 1'b0;
				res.sda_release = 1'b0;
				nxt.step        = ST_STOP_B;
			end
			ST_STOP_B: begin
				res.sda_release = 1'b0;
				nxt.step        = ST_STOP_C;
			end
			ST_STOP_C: begin
				res.data_valid = 1'b1;
				res.read_data  = cur.shift;
				nxt.step       = ST_IDLE;
			end
			default: begin
				res.busy_res  = 1'b0;
				nxt.step      = ST_IDLE;
				nxt.phase     = 1'b0;
				nxt.bit_count = '0;
				if (request_read) begin
					nxt.addr     = word_address;
					nxt.nack     = 1'b0;
					res.busy_res = 1'b1;
					nxt.step     = ST_START;
				end
			end
		endcase
		res.ack_failed = nxt.nack;
	end

endmodule

// ===== rtl/i2c_eeprom_random_read_master_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_random_read_master_unit
// I2C master doing a random byte read from a serial EEPROM, one half bit of
// the bus per accepted tick.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------
//  cfg     | in  | data: 7-bit device code (reset 0x50)
//  req     | in  | request_read, word_address, sda_sample
//  res     | out | scl_level, sda_release, busy_res, data_valid,
//          |     | read_data, ack_failed
//
//  One result per tick transaction, registered in the next cycle; unless
//  stalled, a tick is taken every cycle, sequencer registers updating with it.
//  A stalled result holds the sequencer; req.ready falls only while a result
//  waits and res.ready is low. Reset returns to idle with device code 0x50.
// ----------------------------------------------------------------------------
module i2c_eeprom_random_read_master_unit
	import i2cee_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	i2cee_cfg_if.sink   cfg,
	i2cee_req_if.sink   req,
	i2cee_res_if.source res
);

	seq_state_t            state_q;
	seq_state_t            state_d;
	seq_result_t           result_d;
	seq_result_t           result_q;
	logic                  res_valid_q;
	logic [DEV_CODE_W-1:0] dev_code_q;
	logic                  accept;

	assign cfg.ready = 1'b1;
	assign req.ready = ~res_valid_q | res.ready;
	assign accept    = req.valid & req.ready;

	i2cee_core u_core (
		.cur          (state_q),
		.device_code  (dev_code_q),
		.request_read (req.request_read),
		.word_address (req.word_address),
		.sda_sample   (req.sda_sample),
		.nxt          (state_d),
		.res          (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_code_q <= DEV_CODE_RESET;
		end else if (cfg.valid) begin
			dev_code_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.step      <= ST_IDLE;
			state_q.bit_count <= '0;
			state_q.phase     <= 1'b0;
			state_q.shift     <= '0;
			state_q.addr      <= '0;
			state_q.nack      <= 1'b0;
			res_valid_q       <= 1'b0;
		end else begin
			if (accept)
				state_q <= state_d;
			if (accept)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			result_q <= result_d;
	end

	assign res.valid       = res_valid_q;
	assign res.scl_level   = result_q.scl_level;
	assign res.sda_release = result_q.sda_release;
	assign res.busy_res    = result_q.busy_res;
	assign res.data_valid  = result_q.data_valid;
	assign res.read_data   = result_q.read_data;
	assign res.ack_failed  = result_q.ack_failed;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted tick produced no result");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |=> $stable(state_q.step))
		else $error("sequencer moved while result stalled");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res.data_valid) |-> res.busy_res)
		else $error("data_valid outside a transaction");

	a_idle_bus_released: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.busy_res) |-> (res.scl_level && res.sda_release))
		else $error("bus driven while idle");

	a_done_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && result_d.data_valid) |=> (state_q.step == ST_IDLE))
		else $error("sequencer not idle after completion");

endmodule

// ===== verif/i2cee_bus_checker.sv =====
// ----------------------------------------------------------------------------
// i2cee_bus_checker
// Watches the tick, result and configuration channels of the EEPROM random-
// read I2C master. It predicts the bus levels and status of every accepted
// tick and compares them field by field with the results taken from the block.
// ----------------------------------------------------------------------------
module i2cee_bus_checker
	import i2cee_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	i2cee_cfg_if  cfg,
	i2cee_req_if  req,
	i2cee_res_if  res,
	output int    fail_count,
	output int    pending_ticks
);

	step_t                  seq_step;
	logic [BIT_COUNT_W-1:0] bits_sent;
	logic                   half_phase;
	logic [BYTE_W-1:0]      shift_byte;
	logic [BYTE_W-1:0]      word_addr_q;
	logic                   nack_flag;
	logic [DEV_CODE_W-1:0]  dev_code;

	seq_result_t expected_bus_levels[$];

	// One half-bit tick of the sequencer; updates the model state.
	function automatic seq_result_t predict_bus_tick(input logic rq,
		input logic [BYTE_W-1:0] wa, input logic sda_in);
		seq_result_t r;
		logic        ph;
		ph            = half_phase;
		r.scl_level   = 1'b1;
		r.sda_release = 1'b1;
		r.busy_res    = 1'b1;
		r.data_valid  = 1'b0;
		r.read_data   = '0;
		case (seq_step)
			ST_START: begin
				r.sda_release = 1'b0;
				shift_byte    = {dev_code, 1'b0};
				bits_sent     = '0;
				half_phase    = 1'b0;
				seq_step      = ST_DEVW;
			end
			ST_DEVW, ST_ADDR, ST_DEVR: begin
				r.scl_level   = ph;
				r.sda_release = shift_byte[BYTE_W-1];
				if (ph) begin
					half_phase = 1'b0;
					shift_byte = shift_byte << 1;
					bits_sent  = bits_sent + 1'b1;
					if (bits_sent >= BITS_PER_BYTE) begin
						bits_sent = '0;
						seq_step  = (seq_step == ST_DEVW) ? ST_ACK1 :
							(seq_step == ST_ADDR) ? ST_ACK2 : ST_ACK3;
					end
				end else
					half_phase = 1'b1;
			end
			ST_ACK1, ST_ACK2, ST_ACK3: begin
				r.scl_level = ph;
				if (ph) begin
					half_phase = 1'b0;
					if (sda_in)
						nack_flag = 1'b1;
					if (seq_step == ST_ACK1) begin
						shift_byte = word_addr_q;
						seq_step   = ST_ADDR;
					end else if (seq_step == ST_ACK2)
						seq_step = ST_RS_A;
					else begin
						shift_byte = '0;
						seq_step   = ST_READ;
					end
				end else
					half_phase = 1'b1;
			end
			ST_RS_A: begin
				r.scl_level = 1'b0;
				seq_step    = ST_RS_B;
			end
			ST_RS_B: seq_step = ST_RS_C;
			ST_RS_C: begin
				r.sda_release = 1'b0;
				shift_byte    = {dev_code, 1'b1};
				bits_sent     = '0;
				half_phase    = 1'b0;
				seq_step      = ST_DEVR;
			end
			ST_READ: begin
				r.scl_level = ph;
				if (ph) begin
					half_phase = 1'b0;
					shift_byte = {shift_byte[BYTE_W-2:0], sda_in};
					bits_sent  = bits_sent + 1'b1;
					if (bits_sent >= BITS_PER_BYTE) begin
						bits_sent = '0;
						seq_step  = ST_NACK;
					end
				end else
					half_phase = 1'b1;
			end
			ST_NACK: begin
				r.scl_level = ph;
				if (ph) begin
					half_phase = 1'b0;
					seq_step   = ST_STOP_A;
				end else
					half_phase = 1'b1;
			end
			ST_STOP_A: begin
				r.scl_level   = 1'b0;
				r.sda_release = 1'b0;
				seq_step      = ST_STOP_B;
			end
			ST_STOP_B: begin
				r.sda_release = 1'b0;
				seq_step      = ST_STOP_C;
			end
			ST_STOP_C: begin
				r.data_valid = 1'b1;
				r.read_data  = shift_byte;
				seq_step     = ST_IDLE;
			end
			default: begin
				r.busy_res = 1'b0;
				seq_step   = ST_IDLE;
				half_phase = 1'b0;
				bits_sent  = '0;
				if (rq) begin
					word_addr_q = wa;
					nack_flag   = 1'b0;
					r.busy_res  = 1'b1;
					seq_step    = ST_START;
				end
			end
		endcase
		r.ack_failed = nack_flag;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
		input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_step    = ST_IDLE;
			bits_sent   = '0;
			half_phase  = 1'b0;
			shift_byte  = '0;
			word_addr_q = '0;
			nack_flag   = 1'b0;
			dev_code    = DEV_CODE_RESET;
			expected_bus_levels.delete();
		end else begin
			// results are registered, so one never leaves with its own tick; pop before push
			if (res.valid && res.ready) begin
				if (expected_bus_levels.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time,
						{res.scl_level, res.sda_release, res.busy_res,
						res.data_valid, res.read_data, res.ack_failed});
					fail_count++;
				end else begin
					seq_result_t want;
					want = expected_bus_levels.pop_front();
					check_field("scl_level", BYTE_W'(want.scl_level),
						BYTE_W'(res.scl_level));
					check_field("sda_release", BYTE_W'(want.sda_release),
						BYTE_W'(res.sda_release));
					check_field("busy_res", BYTE_W'(want.busy_res),
						BYTE_W'(res.busy_res));
					check_field("data_valid", BYTE_W'(want.data_valid),
						BYTE_W'(res.data_valid));
					check_field("read_data", want.read_data, res.read_data);
					check_field("ack_failed", BYTE_W'(want.ack_failed),
						BYTE_W'(res.ack_failed));
				end
			end
			if (req.valid && req.ready)
				expected_bus_levels.push_back(predict_bus_tick(req.request_read,
					req.word_address, req.sda_sample));
			if (cfg.valid && cfg.ready)
				dev_code = cfg.data;
		end
		pending_ticks = expected_bus_levels.size();
	end

	initial begin
		fail_count    = 0;
		pending_ticks = 0;
	end

endmodule

// ===== verif/i2c_eeprom_random_read_master_unit_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_random_read_master_unit_tb
// Drives whole random-read sequences, tick by tick, into the I2C master:
// directed reads at the address and data extremes with every ACK and every
// NACK, then random reads under several device codes and idling patterns,
// with one long result hold-off. The checker beside the block does the
// comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module i2c_eeprom_random_read_master_unit_tb;
	import i2cee_pkg::*;

	localparam int READ_TICKS = 80;
	localparam int ACK1_TICK  = 19;
	localparam int ACK2_TICK  = 37;
	localparam int ACK3_TICK  = 58;
	localparam int HOLD_TICKS = 60;

	logic clk;
	logic arst_n;
	int   send_idle_pct = 0;
	int   stall_pct     = 0;
	bit   long_hold     = 1'b0;
	int   fail_count;
	int   pending_ticks;

	i2cee_cfg_if cfg_ch ();
	i2cee_req_if req_ch ();
	i2cee_res_if res_ch ();

	i2c_eeprom_random_read_master_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.res    (res_ch)
	);

	i2cee_bus_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_ch),
		.req           (req_ch),
		.res           (res_ch),
		.fail_count    (fail_count),
		.pending_ticks (pending_ticks)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_TICKS - 1) @(posedge clk);
				long_hold = 1'b0;
			end else
				res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_tick(input logic rq, input logic [BYTE_W-1:0] wa,
		input logic s);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.request_read <= rq;
		req_ch.word_address <= wa;
		req_ch.sda_sample   <= s;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// One full random read from an idle bus; ACK slots get their own bias.
	task automatic bus_read(input logic [BYTE_W-1:0] addr, input int one_pct,
		input int nack_pct);
		logic s;
		for (int i = 0; i < READ_TICKS; i++) begin
			if (i == ACK1_TICK || i == ACK2_TICK || i == ACK3_TICK)
				s = ($urandom_range(99) < nack_pct);
			else
				s = ($urandom_range(99) < one_pct);
			if (i == 0)
				send_tick(1'b1, addr, s);
			else
				send_tick(1'($urandom_range(1)), BYTE_W'($urandom), s);
		end
	endtask

	task automatic drain;
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_ticks != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [DEV_CODE_W-1:0] code, input int snd,
		input int stl, input int reads, input bit pressure);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= code;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid  <= 1'b0;
		send_idle_pct = snd;
		stall_pct     = stl;
		long_hold     = pressure;
		repeat (reads) begin
			repeat ($urandom_range(3))
				send_tick(1'b0, BYTE_W'($urandom), 1'($urandom_range(1)));
			bus_read(BYTE_W'($urandom), 50, 12);
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.request_read <= 1'b0;
		req_ch.word_address <= '0;
		req_ch.sda_sample   <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.data         <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle bus, all-NACK read of 0xff, all-ACK read of 0x00
		send_tick(1'b0, 8'hff, 1'b1);
		send_tick(1'b0, 8'h00, 1'b0);
		bus_read(8'hff, 100, 100);
		bus_read(8'h00, 0, 0);

		run_phase(7'h00, 85, 0, 2, 1'b0);
		run_phase(7'h7f, 0, 85, 2, 1'b0);
		run_phase(DEV_CODE_W'($urandom), 12, 12, 3, 1'b0);
		run_phase(DEV_CODE_W'($urandom), 0, 0, 2, 1'b1);
		run_phase(DEV_CODE_RESET, 12, 12, 2, 1'b0);

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/i2cee_pkg.sv
rtl/i2cee_req_if.sv
rtl/i2cee_res_if.sv
rtl/i2cee_cfg_if.sv
rtl/i2cee_core.sv
rtl/i2c_eeprom_random_read_master_unit.sv
verif/i2cee_bus_checker.sv
verif/i2c_eeprom_random_read_master_unit_tb.sv
